@@ rtl/pbrd_pkg.sv @@
package pbrd_pkg;

  // row count field is two bytes wide above this packed row width
  localparam logic [15:0] WideCountMin = 16'd250;
  localparam logic [7:0]  NoOpHeader   = 8'h80;
  localparam logic [8:0]  RunBase      = 9'd257;

  // configuration register indexes
  localparam logic CfgPackedRowBytes = 1'b0;
  localparam logic CfgRowLimit       = 1'b1;

  localparam int TdataW = 40;

  // one decoded result
  typedef struct packed {
    logic [7:0]         out_value;
    logic [7:0]         run_length;
    logic               row_end;
    logic signed [16:0] bytes_read;
    logic               status;
  } result_t;

endpackage

@@ rtl/pbrd_in_reg.sv @@
module pbrd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // input holding register, refilled in the cycle its byte is consumed
  assign s_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      held_byte <= s_byte;
    end
  end

endmodule

@@ rtl/pbrd_decode.sv @@
module pbrd_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  output logic                  res_valid,
  output pbrd_pkg::result_t     res
);

  typedef enum logic [2:0] {
    PH_COUNT     = 3'd0,
    PH_COUNT_LO  = 3'd1,
    PH_HEADER    = 3'd2,
    PH_RUN_VALUE = 3'd3,
    PH_LITERAL   = 3'd4
  } phase_t;

  logic [15:0]        packed_row_bytes;
  logic [15:0]        row_limit;
  phase_t             phase, phase_next;
  logic [7:0]         count_high, count_high_next;
  logic signed [16:0] remaining, remaining_next;
  logic [16:0]        produced, produced_next;
  logic [7:0]         literal_left, literal_left_next;
  logic [7:0]         pending_run, pending_run_next;
  logic signed [16:0] row_total, row_total_next;

  logic signed [16:0] row_count;
  logic signed [16:0] field_bytes;
  logic [7:0]         pkt_len;
  logic [17:0]        new_total;
  logic               over;
  logic               trim;
  logic [7:0]         lit_dec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      packed_row_bytes <= '0;
      row_limit        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbrd_pkg::CfgPackedRowBytes: packed_row_bytes <= cfg_data;
        pbrd_pkg::CfgRowLimit:       row_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  // row count as signed value with the size of its field
  always_comb begin
    if (phase == PH_COUNT_LO) begin
      row_count   = {{1{count_high[7]}}, count_high, in_byte};
      field_bytes = 17'sd2;
    end else begin
      row_count   = {9'd0, in_byte};
      field_bytes = 17'sd1;
    end
  end

  // packet length and limit check shared by run and literal packets
  always_comb begin
    if (phase == PH_RUN_VALUE) begin
      pkt_len = pending_run;
    end else begin
      pkt_len = in_byte + 8'd1;
    end
    new_total = {1'b0, produced} + {10'd0, pkt_len};
    over      = new_total > {2'd0, row_limit};
    trim      = row_limit[0] && (new_total == ({2'd0, row_limit} + 18'd1));
    lit_dec   = (literal_left != 8'd0) ? literal_left - 8'd1 : literal_left;
  end

  // next state and result for the held byte
  always_comb begin
    phase_next        = phase;
    count_high_next   = count_high;
    remaining_next    = remaining;
    produced_next     = produced;
    literal_left_next = literal_left;
    pending_run_next  = pending_run;
    row_total_next    = row_total;
    res_valid         = 1'b0;
    res               = '0;
    unique case (phase) inside
      PH_COUNT, PH_COUNT_LO: begin
        if (phase == PH_COUNT && packed_row_bytes > pbrd_pkg::WideCountMin) begin
          count_high_next = in_byte;
          phase_next      = PH_COUNT_LO;
        end else begin
          row_total_next    = row_count + field_bytes;
          remaining_next    = row_count;
          produced_next     = '0;
          literal_left_next = '0;
          pending_run_next  = '0;
          if (row_count[16] || row_count == 17'sd0) begin
            phase_next     = PH_COUNT;
            res_valid      = 1'b1;
            res.row_end    = 1'b1;
            res.bytes_read = row_count + field_bytes;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if (in_byte == pbrd_pkg::NoOpHeader) begin
          remaining_next = remaining - 17'sd1;
          if (remaining_next[16] || remaining_next == 17'sd0) begin
            phase_next     = PH_COUNT;
            res_valid      = 1'b1;
            res.row_end    = 1'b1;
            res.bytes_read = row_total;
          end
        end else if (in_byte[7]) begin
          pending_run_next = 8'(pbrd_pkg::RunBase - {1'b0, in_byte});
          phase_next       = PH_RUN_VALUE;
        end else if (over) begin
          // literal packet past the row limit: abandon the row
          phase_next        = PH_COUNT;
          literal_left_next = '0;
          pending_run_next  = '0;
          res_valid         = 1'b1;
          res.row_end       = 1'b1;
          res.status        = 1'b1;
        end else begin
          remaining_next    = remaining - $signed({8'd0, pkt_len} + 17'd1);
          produced_next     = new_total[16:0];
          literal_left_next = pkt_len;
          phase_next        = PH_LITERAL;
        end
      end
      PH_RUN_VALUE: begin
        if (over && !trim) begin
          phase_next        = PH_COUNT;
          literal_left_next = '0;
          pending_run_next  = '0;
          res_valid         = 1'b1;
          res.row_end       = 1'b1;
          res.status        = 1'b1;
        end else begin
          remaining_next   = remaining - 17'sd2;
          pending_run_next = '0;
          res_valid        = 1'b1;
          res.out_value    = in_byte;
          // odd limit overshot by one trims the run
          if (over) begin
            res.run_length = pkt_len - 8'd1;
            produced_next  = new_total[16:0] - 17'd1;
          end else begin
            res.run_length = pkt_len;
            produced_next  = new_total[16:0];
          end
          if (remaining_next[16] || remaining_next == 17'sd0) begin
            phase_next     = PH_COUNT;
            res.row_end    = 1'b1;
            res.bytes_read = row_total;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end
      PH_LITERAL: begin
        literal_left_next = lit_dec;
        res_valid         = 1'b1;
        res.out_value     = in_byte;
        res.run_length    = 8'd1;
        if (lit_dec == 8'd0) begin
          if (remaining[16] || remaining == 17'sd0) begin
            phase_next     = PH_COUNT;
            res.row_end    = 1'b1;
            res.bytes_read = row_total;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end
      default: begin
        phase_next = PH_COUNT;
      end
    endcase
  end

  // decoder state, advanced once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      count_high   <= '0;
      remaining    <= '0;
      produced     <= '0;
      literal_left <= '0;
      pending_run  <= '0;
      row_total    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      count_high   <= count_high_next;
      remaining    <= remaining_next;
      produced     <= produced_next;
      literal_left <= literal_left_next;
      pending_run  <= pending_run_next;
      row_total    <= row_total_next;
    end
  end

endmodule

@@ rtl/pbrd_out_skid.sv @@
module pbrd_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbrd_pkg::result_t in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output pbrd_pkg::result_t out_res
);

  logic              skid_valid;
  pbrd_pkg::result_t skid_res;

  // ready depends on registered state only
  assign in_ready = !skid_valid;

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (out_valid && !out_ready) begin
        skid_res <= in_res;
      end else begin
        out_res <= in_res;
      end
    end else if (out_ready && skid_valid) begin
      out_res <= skid_res;
    end
  end

endmodule

@@ rtl/packbits_row_decoder.sv @@
// channel    | dir | handshake              | payload
// s_axis     | in  | s_axis_tvalid/tready   | tdata[7:0] in_byte
// m_axis     | out | m_axis_tvalid/tready   | tdata, tlast row_end, tuser status
// cfg        | in  | cfg_we                 | cfg_index, cfg_data[15:0]
//
// one packed byte is consumed per cycle while the skid entry is empty; a byte is
// accepted into the input holding register, which feeds the result register directly
// first bytes of two-byte counts give no result, headers only when ending a row
// rst is synchronous and clears the decoder state and both config registers
// a stalled output is absorbed by a one-entry skid, after which input stalls
module packbits_row_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_value, [15:8] run_length, [32:16] bytes_read, [39:33] zero
  output logic [pbrd_pkg::TdataW-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast,  // row_end
  output logic                          m_axis_tuser   // [0] status
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              take;
  logic              res_valid;
  logic              skid_ready;
  pbrd_pkg::result_t res;
  pbrd_pkg::result_t out_res;

  // a held byte is consumed whenever the output side has room
  assign take = held_valid && skid_ready;

  pbrd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_byte     (s_axis_tdata),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  pbrd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .in_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  pbrd_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take && res_valid),
    .in_ready  (skid_ready),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // output packing
  assign m_axis_tdata = {7'd0, out_res.bytes_read, out_res.run_length, out_res.out_value};
  assign m_axis_tlast = out_res.row_end;
  assign m_axis_tuser = out_res.status;

endmodule

@@ tb/tb_packbits_row_decoder.sv @@
`timescale 1ns / 1ps

module tb_packbits_row_decoder;

  localparam int TOTAL_BYTES  = 1400;
  localparam int PHASE_BYTES  = 150;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_SLACK = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_ROWS     = 31;

  localparam pbrd_pkg::result_t NO_RESULT = '0;

  // decoder position within a row
  typedef enum logic [2:0] {
    AWAIT_COUNT,
    AWAIT_COUNT_LO,
    AWAIT_HEADER,
    AWAIT_RUN_VALUE,
    IN_LITERAL
  } dec_phase_t;

  // kinds of directed step
  typedef enum logic [1:0] {
    STEP_BYTE,
    STEP_TYPED,
    STEP_CFG_PRB,
    STEP_CFG_LIMIT
  } step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [15:0]        value;
    pbrd_pkg::result_t  want;
  } dir_step_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [15:0]                   cfg_data;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [pbrd_pkg::TdataW-1:0]   m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;

  // predictor copy of registers and decoder state
  logic [15:0]  cur_packed_row_bytes = '0;
  logic [15:0]  cur_row_limit        = '0;
  dec_phase_t   dec_phase            = AWAIT_COUNT;
  logic [7:0]   dec_count_high       = '0;
  int           dec_remaining        = 0;
  int           dec_produced         = 0;
  int           dec_literal_left     = 0;
  int           dec_pending_run      = 0;
  int           dec_row_total        = 0;

  pbrd_pkg::result_t  expected_runs[$];
  logic [7:0]         row_bytes[$];
  dir_step_t          dir_steps [DIR_ROWS];

  int  mismatches  = 0;
  int  bytes_sent  = 0;
  int  idle_cycles = 0;
  int  rx_hold     = 0;
  bit  tx_quiet    = 1'b0;
  bit  rx_quiet    = 1'b0;

  packbits_row_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [7:0] out_value, [15:8] run_length, [32:16] bytes_read, [39:33] zero
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),   // row_end
    .m_axis_tuser  (m_axis_tuser)    // [0] status
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one packed byte through the decoder; got is set when it closes a run or row
  task automatic decode_byte(input logic [7:0] b, output bit got,
                             output pbrd_pkg::result_t r);
    int  cnt;
    int  field_bytes;
    int  len;
    bit  fin;
    bit  begin_row;
    bit  overflow;
    got = 1'b0;
    r = NO_RESULT;
    begin_row = 1'b0;
    overflow = 1'b0;
    cnt = 0;
    field_bytes = 0;
    case (dec_phase)
      AWAIT_COUNT: begin
        if (cur_packed_row_bytes > pbrd_pkg::WideCountMin) begin
          dec_count_high = b;
          dec_phase = AWAIT_COUNT_LO;
        end else begin
          cnt = int'(b);
          field_bytes = 1;
          begin_row = 1'b1;
        end
      end
      AWAIT_COUNT_LO: begin
        cnt = int'($signed({dec_count_high, b}));
        field_bytes = 2;
        begin_row = 1'b1;
      end
      AWAIT_HEADER: begin
        if (b == pbrd_pkg::NoOpHeader) begin
          dec_remaining--;
          if (dec_remaining <= 0) begin
            dec_phase = AWAIT_COUNT;
            got = 1'b1;
            r.row_end = 1'b1;
            r.bytes_read = 17'(dec_row_total);
          end
        end else if (b[7]) begin
          dec_pending_run = int'(pbrd_pkg::RunBase) - int'(b);
          dec_phase = AWAIT_RUN_VALUE;
        end else begin
          len = int'(b) + 1;
          if (dec_produced + len > int'(cur_row_limit)) begin
            overflow = 1'b1;
          end else begin
            dec_remaining -= len + 1;
            dec_produced += len;
            dec_literal_left = len;
            dec_phase = IN_LITERAL;
          end
        end
      end
      AWAIT_RUN_VALUE: begin
        len = dec_pending_run;
        if (dec_produced + len > int'(cur_row_limit)) begin
          // odd limit overshot by one trims the run instead of failing
          if (cur_row_limit[0] && dec_produced + len == int'(cur_row_limit) + 1) len--;
          else overflow = 1'b1;
        end
        if (!overflow) begin
          dec_remaining -= 2;
          dec_produced += len;
          dec_pending_run = 0;
          fin = dec_remaining <= 0;
          dec_phase = fin ? AWAIT_COUNT : AWAIT_HEADER;
          got = 1'b1;
          r.out_value = b;
          r.run_length = 8'(len);
          r.row_end = fin;
          r.bytes_read = fin ? 17'(dec_row_total) : '0;
        end
      end
      IN_LITERAL: begin
        fin = 1'b0;
        if (dec_literal_left > 0) dec_literal_left--;
        if (dec_literal_left == 0) begin
          fin = dec_remaining <= 0;
          dec_phase = fin ? AWAIT_COUNT : AWAIT_HEADER;
        end
        got = 1'b1;
        r.out_value = b;
        r.run_length = 8'd1;
        r.row_end = fin;
        r.bytes_read = fin ? 17'(dec_row_total) : '0;
      end
      default: dec_phase = AWAIT_COUNT;
    endcase

    // row count complete
    if (begin_row) begin
      dec_row_total = field_bytes + cnt;
      dec_remaining = cnt;
      dec_produced = 0;
      dec_literal_left = 0;
      dec_pending_run = 0;
      if (cnt <= 0) begin
        dec_phase = AWAIT_COUNT;
        got = 1'b1;
        r.row_end = 1'b1;
        r.bytes_read = 17'(dec_row_total);
      end else begin
        dec_phase = AWAIT_HEADER;
      end
    end

    // row abandoned, decoder waits for a fresh count
    if (overflow) begin
      dec_phase = AWAIT_COUNT;
      dec_literal_left = 0;
      dec_pending_run = 0;
      got = 1'b1;
      r = NO_RESULT;
      r.row_end = 1'b1;
      r.status = 1'b1;
    end
  endtask

  // offer one byte after a random gap and predict on acceptance
  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input pbrd_pkg::result_t want);
    int                 gap;
    bit                 got;
    pbrd_pkg::result_t  r;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    decode_byte(b, got, r);
    if (typed) expected_runs.push_back(want);
    else if (got) expected_runs.push_back(r);
    bytes_sent++;
  endtask

  task automatic tx_stop();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_runs.size() != 0) @(posedge clk);
  endtask

  // idle the input and let the pipeline empty before touching registers
  task automatic settle();
    tx_stop();
    wait_drained();
    repeat (SETTLE_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pbrd_pkg::CfgPackedRowBytes) cur_packed_row_bytes = val;
    else cur_row_limit = val;
  endtask

  // one packed row, mostly well formed, sometimes stray bytes or a bad count
  task automatic gen_row();
    logic [7:0]  body[$];
    int          target;
    int          glen;
    int          made;
    int          cnt;
    int          need;
    bit          wide;
    wide = cur_packed_row_bytes > pbrd_pkg::WideCountMin;
    row_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) row_bytes.push_back(8'($urandom));
      return;
    end
    if ($urandom_range(0, 11) == 0) begin
      // empty or negative row count
      case ($urandom_range(0, 3))
        0: cnt = 0;
        1: cnt = -1;
        2: cnt = -32768;
        default: cnt = -int'($urandom_range(2, 32767));
      endcase
      if (!wide) cnt = 0;
    end else begin
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, wide ? 300 : 120)
                                            : $urandom_range(1, 24);
      made = 0;
      while (body.size() < target) begin
        case ($urandom_range(0, 5))
          0: body.push_back(pbrd_pkg::NoOpHeader);
          1, 2: begin
            glen = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 128) : $urandom_range(2, 10);
            // aim at the odd limit plus one now and then
            need = int'(cur_row_limit) + 1 - made;
            if (cur_row_limit[0] && need >= 2 && need <= 128 && $urandom_range(0, 3) == 0)
              glen = need;
            body.push_back(8'(int'(pbrd_pkg::RunBase) - glen));
            body.push_back(8'($urandom));
            made += glen;
          end
          default: begin
            glen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            body.push_back(8'(glen - 1));
            repeat (glen) body.push_back(8'($urandom));
            made += glen;
          end
        endcase
      end
      cnt = body.size();
      if ($urandom_range(0, 9) == 0) cnt = cnt + int'($urandom_range(0, 6)) - 3;
    end
    if (wide) row_bytes.push_back(8'(cnt >>> 8));
    row_bytes.push_back(8'(cnt));
    foreach (body[i]) row_bytes.push_back(body[i]);
  endtask

  // result side: random back-pressure, with one long hold-off on request
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 11);
      if (rx_hold != 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    pbrd_pkg::result_t want;
    pbrd_pkg::result_t seen;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.out_value = m_axis_tdata[7:0];
      seen.run_length = m_axis_tdata[15:8];
      seen.row_end = m_axis_tlast;
      seen.bytes_read = m_axis_tdata[32:16];
      seen.status = m_axis_tuser;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result value=%0d len=%0d end=%0b read=%0d status=%0b",
                   $time, seen.out_value, seen.run_length, seen.row_end,
                   seen.bytes_read, seen.status);
      end else begin
        want = expected_runs.pop_front();
        if (seen != want || m_axis_tdata[pbrd_pkg::TdataW-1:33] != '0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result mismatch exp value=%0d len=%0d end=%0b read=%0d status=%0b",
                     $time, want.out_value, want.run_length, want.row_end,
                     want.bytes_read, want.status);
          if (mismatches <= REPORT_MAX)
            $display("%0t:   got value=%0d len=%0d end=%0b read=%0d status=%0b pad=%0h",
                     $time, seen.out_value, seen.run_length, seen.row_end,
                     seen.bytes_read, seen.status, m_axis_tdata[pbrd_pkg::TdataW-1:33]);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_packbits_row_decoder: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin : stimulus
    int           p;
    int           phase_start;
    bit           paused;
    logic [15:0]  prb;
    logic [15:0]  lim;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = pbrd_pkg::CfgPackedRowBytes;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;

    dir_steps = '{
      // reset registers: one-byte count, nothing may be produced
      '{STEP_TYPED,     16'h0000, '{8'h00, 8'd0, 1'b1, 17'sd1, 1'b0}},
      '{STEP_BYTE,      16'h0002, NO_RESULT},
      '{STEP_BYTE,      16'h0080, NO_RESULT},
      '{STEP_TYPED,     16'h0080, '{8'h00, 8'd0, 1'b1, 17'sd3, 1'b0}},
      '{STEP_BYTE,      16'h0001, NO_RESULT},
      '{STEP_TYPED,     16'h0000, '{8'h00, 8'd0, 1'b1, 17'sd0, 1'b1}},
      // widest limit, last one-byte-count width
      '{STEP_CFG_LIMIT, 16'hFFFF, NO_RESULT},
      '{STEP_CFG_PRB,   16'd250,  NO_RESULT},
      '{STEP_BYTE,      16'h0004, NO_RESULT},
      '{STEP_BYTE,      16'h0081, NO_RESULT},
      '{STEP_TYPED,     16'h00FF, '{8'hFF, 8'd128, 1'b0, 17'sd0, 1'b0}},
      '{STEP_BYTE,      16'h0001, NO_RESULT},
      '{STEP_BYTE,      16'h00AA, NO_RESULT},
      '{STEP_BYTE,      16'h0055, NO_RESULT},
      // two-byte signed count, odd limit
      '{STEP_CFG_PRB,   16'd251,  NO_RESULT},
      '{STEP_CFG_LIMIT, 16'd3,    NO_RESULT},
      '{STEP_BYTE,      16'h0080, NO_RESULT},
      '{STEP_TYPED,     16'h0000, '{8'h00, 8'd0, 1'b1, -17'sd32766, 1'b0}},
      '{STEP_BYTE,      16'h007F, NO_RESULT},
      '{STEP_BYTE,      16'h00FF, NO_RESULT},
      '{STEP_BYTE,      16'h00FD, NO_RESULT},
      '{STEP_BYTE,      16'h0000, NO_RESULT},
      '{STEP_BYTE,      16'h00FF, NO_RESULT},
      '{STEP_TYPED,     16'h0012, '{8'h00, 8'd0, 1'b1, 17'sd0, 1'b1}},
      '{STEP_BYTE,      16'h00FF, NO_RESULT},
      '{STEP_TYPED,     16'h00FF, '{8'h00, 8'd0, 1'b1, 17'sd1, 1'b0}},
      // widest packed row, zero limit, longest literal header
      '{STEP_CFG_PRB,   16'hFFFF, NO_RESULT},
      '{STEP_CFG_LIMIT, 16'd0,    NO_RESULT},
      '{STEP_BYTE,      16'h0000, NO_RESULT},
      '{STEP_BYTE,      16'h0005, NO_RESULT},
      '{STEP_TYPED,     16'h007F, '{8'h00, 8'd0, 1'b1, 17'sd0, 1'b1}}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_steps[i].kind)
        STEP_CFG_PRB: begin
          settle();
          write_reg(pbrd_pkg::CfgPackedRowBytes, dir_steps[i].value);
        end
        STEP_CFG_LIMIT: begin
          settle();
          write_reg(pbrd_pkg::CfgRowLimit, dir_steps[i].value);
        end
        default: send_byte(dir_steps[i].value[7:0], dir_steps[i].kind == STEP_TYPED,
                           dir_steps[i].want);
      endcase
    end

    // random rows, a fresh register setting per phase
    p = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      settle();
      case (p % 4)
        0: prb = 16'd0;
        1: prb = 16'($urandom_range(1, 250));
        2: prb = 16'($urandom_range(251, 65534));
        default: prb = 16'hFFFF;
      endcase
      case ($urandom_range(0, 4))
        0: lim = 16'd0;
        1: lim = 16'hFFFF;
        2: lim = 16'($urandom_range(1, 400)) | 16'd1;
        3: lim = 16'($urandom_range(1, 400));
        default: lim = 16'($urandom_range(401, 65534));
      endcase
      if (p < 3) lim = 16'hFFFF;
      write_reg(pbrd_pkg::CfgPackedRowBytes, prb);
      write_reg(pbrd_pkg::CfgRowLimit, lim);
      tx_quiet = (p == 1) || ($urandom_range(0, 4) == 0);
      rx_quiet = (p == 1) || ($urandom_range(0, 4) == 0);
      // long receiver hold-off while bytes keep coming
      if (p == 2) rx_hold = HOLD_CYCLES;
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // sender pause until all results are back
        if (p == 3 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
          paused = 1'b1;
          tx_stop();
          wait_drained();
        end
        gen_row();
        foreach (row_bytes[i]) send_byte(row_bytes[i], 1'b0, NO_RESULT);
      end
      p++;
    end

    // drain and finish
    tx_stop();
    rx_quiet = 1'b0;
    wait_drained();
    repeat (SETTLE_SLACK + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_packbits_row_decoder: clean");
    end else begin
      $display("tb_packbits_row_decoder: errors");
    end
    $finish;
  end

endmodule
